[hdl/rau_pkg.sv]
// rau_pkg: shared types and constants for the rational arithmetic unit
// no dependencies
package rau_pkg;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [2:0] {
        ACT_NORM = 3'd0,
        ACT_ADD  = 3'd1,
        ACT_SUB  = 3'd2,
        ACT_MUL  = 3'd3,
        ACT_DIV  = 3'd4,
        ACT_EQ   = 3'd5
    } action_t;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef enum logic [3:0] {
        OP_LOAD_A = 4'd0,
        OP_LOAD_B = 4'd1,
        OP_GCD    = 4'd2,
        OP_SAVE_A = 4'd3,
        OP_SAVE_B = 4'd4,
        OP_MUL1   = 4'd5,
        OP_MUL2   = 4'd6,
        OP_COMB   = 4'd7,
        OP_NONE   = 4'd8
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic busy;
    } sts_t;
endpackage

[hdl/rau_datapath.sv]
// rau_datapath: operand registers, serial multiplier, gcd and exact divider
// depends on rau_pkg
module rau_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  rau_pkg::cmd_t       cmd,
    output rau_pkg::sts_t       sts,
    input  logic signed [31:0]  a_num,
    input  logic signed [31:0]  a_den,
    input  logic signed [31:0]  b_num,
    input  logic signed [31:0]  b_den,
    input  logic [2:0]          action,
    output logic                bzero,
    output logic                eq,
    output logic [63:0]         r_mag,
    output logic [63:0]         r_den,
    output logic                r_neg
);
    import rau_pkg::*;

    typedef enum logic [4:0] {
        U_IDLE = 5'b00001,
        U_MUL  = 5'b00010,
        U_GCD  = 5'b00100,
        U_DIVN = 5'b01000,
        U_DIVD = 5'b10000
    } ustate_t;

    ustate_t u_reg, u_next;
    logic [63:0] x_reg, y_reg;       // working numerator / denominator
    logic        n_reg;
    logic [63:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic        as_reg, bs_reg;
    logic [63:0] g_reg, h_reg;       // gcd pair
    logic [63:0] dv_rem_reg, dv_q_reg, dv_src_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] m_acc_reg, m_a_reg, m_b_reg;
    logic [63:0] t1_reg;
    logic [1:0]  mstep_reg;
    logic [63:0] mod_rem_reg;
    logic        mod_run_reg;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

    logic [64:0] trial;
    logic [64:0] trial_h;

    always_comb
    begin
        trial   = {dv_rem_reg[63:0], dv_src_reg[63]} - {1'b0, g_reg};
        trial_h = {mod_rem_reg, dv_src_reg[63]} - {1'b0, h_reg};
    end

    assign sts.busy = (u_reg != U_IDLE);
    assign bzero = (bn_reg == 64'd0);
    assign eq = (as_reg == bs_reg) && (an_reg == bn_reg) && (ad_reg == bd_reg);
    assign r_mag = x_reg;
    assign r_den = y_reg;
    assign r_neg = n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_reg <= U_IDLE;
        end
        else
        begin
            u_reg <= u_next;
        end
    end

    // one-bit-per-cycle engines: shift-add multiply, gcd by repeated mod, restoring divide
    always_comb
    begin
        u_next = u_reg;
        unique case (u_reg)
            U_IDLE:
            begin
                if (cmd.start)
                begin
                    if (cmd.op == OP_GCD) u_next = U_GCD;
                    else if (cmd.op == OP_MUL1 || cmd.op == OP_MUL2 || cmd.op == OP_COMB)
                        u_next = U_MUL;
                end
            end
            U_MUL:  if (cnt_reg == 7'd64 && mstep_reg == 2'd0) u_next = U_IDLE;
            U_GCD:  if (h_reg == 64'd0 && !mod_run_reg) u_next = U_DIVN;
            U_DIVN: if (cnt_reg == 7'd64) u_next = U_DIVD;
            U_DIVD: if (cnt_reg == 7'd64) u_next = U_IDLE;
            default: u_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (u_reg)
            U_IDLE:
            begin
                cnt_reg <= 7'd0;
                mod_run_reg <= 1'b0;
                if (cmd.start)
                begin
                    case (cmd.op)
                        OP_LOAD_A:
                        begin
                            x_reg <= {32'd0, mag32(a_num)};
                            y_reg <= {32'd0, mag32(a_den)};
                            n_reg <= a_num[31] ^ a_den[31];
                        end
                        OP_LOAD_B:
                        begin
                            x_reg <= {32'd0, mag32(b_num)};
                            y_reg <= {32'd0, mag32(b_den)};
                            n_reg <= b_num[31] ^ b_den[31];
                        end
                        OP_GCD:
                        begin
                            g_reg <= x_reg;
                            h_reg <= y_reg;
                        end
                        OP_SAVE_A:
                        begin
                            an_reg <= x_reg; ad_reg <= y_reg;
                            as_reg <= (x_reg != 64'd0) & n_reg;
                        end
                        OP_SAVE_B:
                        begin
                            bn_reg <= x_reg; bd_reg <= y_reg;
                            // subtract flips the sign of b
                            bs_reg <= (x_reg != 64'd0) & (n_reg ^ (action == ACT_SUB));
                        end
                        OP_MUL1, OP_MUL2, OP_COMB:
                        begin
                            mstep_reg <= 2'd0;
                            m_acc_reg <= 64'd0;
                            if (cmd.op == OP_MUL1)
                            begin
                                m_a_reg <= an_reg;
                                m_b_reg <= (action == ACT_DIV) ? bd_reg :
                                           (action == ACT_MUL) ? bn_reg : bd_reg;
                            end
                            else if (cmd.op == OP_MUL2)
                            begin
                                m_a_reg <= ad_reg;
                                m_b_reg <= (action == ACT_DIV) ? bn_reg :
                                           (action == ACT_MUL) ? bd_reg : bn_reg;
                            end
                            else
                            begin
                                m_a_reg <= ad_reg;
                                m_b_reg <= bd_reg;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            U_MUL:
            begin
                if (cnt_reg != 7'd64)
                begin
                    if (m_b_reg[cnt_reg[5:0]]) m_acc_reg <= m_acc_reg + (m_a_reg << cnt_reg[5:0]);
                    cnt_reg <= cnt_reg + 7'd1;
                end
                else
                begin
                    // product: mul1 -> x,t1; mul2 -> y (add/sub: x=t1+/-it); comb -> y
                    if (cmd.op == OP_MUL1) begin x_reg <= m_acc_reg; t1_reg <= m_acc_reg; end
                    else if (cmd.op == OP_MUL2)
                    begin
                        if (action == ACT_MUL || action == ACT_DIV)
                        begin
                            y_reg <= m_acc_reg;
                            n_reg <= as_reg ^ bs_reg;
                        end
                        else if (as_reg == bs_reg)
                        begin
                            x_reg <= t1_reg + m_acc_reg; n_reg <= as_reg;
                        end
                        else if (t1_reg >= m_acc_reg)
                        begin
                            x_reg <= t1_reg - m_acc_reg; n_reg <= as_reg;
                        end
                        else
                        begin
                            x_reg <= m_acc_reg - t1_reg; n_reg <= bs_reg;
                        end
                    end
                    else y_reg <= m_acc_reg;
                end
            end
            U_GCD:
            begin
                // g mod h bit-serially, then swap
                if (h_reg != 64'd0)
                begin
                    if (!mod_run_reg)
                    begin
                        mod_run_reg <= 1'b1;
                        mod_rem_reg <= 64'd0;
                        dv_src_reg <= g_reg;
                        cnt_reg <= 7'd0;
                    end
                    else if (cnt_reg != 7'd64)
                    begin
                        if (trial_h[64]) mod_rem_reg <= {mod_rem_reg[62:0], dv_src_reg[63]};
                        else mod_rem_reg <= trial_h[63:0];
                        dv_src_reg <= {dv_src_reg[62:0], 1'b0};
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                    else
                    begin
                        g_reg <= h_reg;
                        h_reg <= mod_rem_reg;
                        mod_run_reg <= 1'b0;
                    end
                end
                else
                begin
                    if (g_reg == 64'd0) g_reg <= 64'd1;
                    dv_src_reg <= x_reg;
                    dv_rem_reg <= 64'd0;
                    cnt_reg <= 7'd0;
                    mod_run_reg <= 1'b0;
                end
            end
            U_DIVN, U_DIVD:
            begin
                if (cnt_reg != 7'd64)
                begin
                    if (trial[64])
                    begin
                        dv_rem_reg <= {dv_rem_reg[62:0], dv_src_reg[63]};
                        dv_q_reg <= {dv_q_reg[62:0], 1'b0};
                    end
                    else
                    begin
                        dv_rem_reg <= trial[63:0];
                        dv_q_reg <= {dv_q_reg[62:0], 1'b1};
                    end
                    dv_src_reg <= {dv_src_reg[62:0], 1'b0};
                    cnt_reg <= cnt_reg + 7'd1;
                end
                else
                begin
                    cnt_reg <= 7'd0;
                    dv_rem_reg <= 64'd0;
                    if (u_reg == U_DIVN)
                    begin
                        x_reg <= dv_q_reg;
                        dv_src_reg <= y_reg;
                    end
                    else y_reg <= dv_q_reg;
                end
            end
            default: ;
        endcase
    end
endmodule

[hdl/rau_ctrl.sv]
// rau_ctrl: sequencer issuing datapath commands for one item
// depends on rau_pkg
module rau_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_go,
    input  logic [2:0]    action,
    input  logic          err_in,
    input  logic          bzero,
    input  logic          hold,
    input  rau_pkg::sts_t sts,
    output rau_pkg::cmd_t cmd,
    output logic          done,
    output logic          div0
);
    import rau_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ISS  = 7'b0000010,
        S_WAIT = 7'b0000100,
        S_NEXT = 7'b0001000,
        S_DONE = 7'b0010000,
        S_DZ   = 7'b0100000,
        S_X    = 7'b1000000
    } state_t;

    state_t st_reg, st_next;
    logic [3:0] pc_reg, pc_next;

    // program: loadA gcd saveA loadB gcd saveB mul1 mul2 [comb] gcd
    function automatic op_t prog(input logic [3:0] pc);
        case (pc)
            4'd0: prog = OP_LOAD_A;
            4'd1: prog = OP_GCD;
            4'd2: prog = OP_SAVE_A;
            4'd3: prog = OP_LOAD_B;
            4'd4: prog = OP_GCD;
            4'd5: prog = OP_SAVE_B;
            4'd6: prog = OP_MUL1;
            4'd7: prog = OP_MUL2;
            4'd8: prog = OP_COMB;
            4'd9: prog = OP_GCD;
            default: prog = OP_NONE;
        endcase
    endfunction

    assign cmd.op = prog(pc_reg);
    assign cmd.start = (st_reg == S_ISS);
    assign done = (st_reg == S_DONE);
    assign div0 = (st_reg == S_DZ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            pc_reg <= 4'd0;
        end
        else
        begin
            st_reg <= st_next;
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        pc_next = pc_reg;
        unique case (st_reg)
            S_IDLE: if (in_go) begin st_next = err_in ? S_DONE : S_ISS; pc_next = 4'd0; end
            S_ISS:  st_next = S_WAIT;
            S_WAIT: if (!sts.busy) st_next = S_NEXT;
            S_NEXT:
            begin
                st_next = S_ISS;
                pc_next = pc_reg + 4'd1;
                if (action == ACT_NORM && pc_reg == 4'd2) st_next = S_DONE;
                if (pc_reg == 4'd5)
                begin
                    if (action == ACT_EQ) st_next = S_DONE;
                    else if (action == ACT_DIV && bzero) st_next = S_DZ;
                end
                if (pc_reg == 4'd7 && (action == ACT_MUL || action == ACT_DIV))
                    pc_next = 4'd9;
                if (pc_reg == 4'd9) st_next = S_DONE;
            end
            // wait here while the previous result is still held at the output
            S_DONE, S_DZ: if (!hold) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end
endmodule

[hdl/rational_arithmetic_unit.sv]
// rational_arithmetic_unit: top level, input/output registers around ctrl and datapath
// depends on rau_pkg, rau_ctrl, rau_datapath
//  channel | signals                              | dir
//  in      | in_valid in_stall action a_* b_*     | in
//  out     | out_valid out_stall res_* is_equal status | out
// one item at a time; the run time of an item depends on the number of euclid
// steps in its gcd passes; each reduction adds two serial divides, each product
// a serial multiply; error items finish without running the datapath
// reset clears control; a held result only delays the finish of the next item,
// which may be accepted as soon as the previous result is registered
module rational_arithmetic_unit #(
    parameter int VALUE_BITS = rau_pkg::VALUE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] res_num,
    output logic [30:0]        res_den,
    output logic               is_equal,
    output logic [1:0]         status
);
    import rau_pkg::*;

    logic busy_reg;
    logic [2:0] act_reg;
    logic signed [31:0] an_reg, ad_reg, bn_reg, bd_reg;
    cmd_t cmd;
    sts_t sts;
    logic done, div0, bzero, eq, r_neg, go_reg, err_reg;
    logic hold, load;
    logic [63:0] r_mag, r_den;
    localparam logic [63:0] LIMIT = (64'd1 << (VALUE_BITS - 1)) - 64'd1;

    assign in_stall = busy_reg;
    assign hold = out_valid && out_stall;
    assign load = (done || div0) && !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            out_valid <= 1'b0;
            go_reg <= 1'b0;
        end
        else
        begin
            go_reg <= in_valid && !in_stall;
            if (in_valid && !in_stall) busy_reg <= 1'b1;
            else if (load) busy_reg <= 1'b0;
            if (load) out_valid <= 1'b1;
            else if (out_valid && !out_stall) out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            act_reg <= action;
            an_reg <= a_num; ad_reg <= a_den; bn_reg <= b_num; bd_reg <= b_den;
            err_reg <= (action > ACT_EQ) || (a_den == 32'sd0) ||
                       (action != ACT_NORM && b_den == 32'sd0);
        end
        if (load)
        begin
            if (err_reg || div0)
            begin
                res_num <= 32'sd0; res_den <= 31'd1; is_equal <= 1'b0;
                status <= ST_ZERO;
            end
            else if (act_reg == ACT_EQ)
            begin
                res_num <= 32'sd0; res_den <= 31'd1; is_equal <= eq;
                status <= ST_OK;
            end
            else if (r_mag > LIMIT || r_den > LIMIT)
            begin
                res_num <= 32'sd0; res_den <= 31'd1; is_equal <= 1'b0;
                status <= ST_OVF;
            end
            else
            begin
                status <= ST_OK; is_equal <= 1'b0;
                res_num <= r_neg ? (32'd0 - r_mag[31:0]) : r_mag[31:0];
                res_den <= r_den[30:0];
            end
        end
    end

    rau_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_go(go_reg), .action(act_reg), .err_in(err_reg),
        .bzero(bzero), .hold(hold), .sts(sts), .cmd(cmd), .done(done), .div0(div0)
    );

    rau_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .a_num(an_reg), .a_den(ad_reg), .b_num(bn_reg), .b_den(bd_reg),
        .action(act_reg), .bzero(bzero), .eq(eq), .r_mag(r_mag), .r_den(r_den),
        .r_neg(r_neg)
    );

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done || div0) |=> out_valid) else $error("result lost");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(res_num) && $stable(res_den)
        && $stable(is_equal) && $stable(status))) else $error("stalled result changed");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(done && div0)) else $error("double finish");
endmodule
